>>> rtl/polyphase_interpolator_2x_core_defines.svh
// Assertion macros used by the checker file.
`ifndef POLYPHASE_INTERPOLATOR_2X_CORE_DEFINES_SVH
`define POLYPHASE_INTERPOLATOR_2X_CORE_DEFINES_SVH

// Checked only while the reset is released.
`define PI2X_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

// Checked at every edge, including those in reset.
`define PI2X_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) \
        else $error(msg);

`endif

>>> rtl/pi2x_pkg.sv
package pi2x_pkg;

    localparam int MAX_TAPS    = 64;
    localparam int SAMPLE_BITS = 24;
    localparam int COEF_BITS   = 24;

    localparam int ADDR_W = $clog2(MAX_TAPS);
    localparam int LEN_W  = $clog2(MAX_TAPS + 1);
    localparam int CFG_W  = 7;
    localparam int IDX_W  = 6;
    localparam int OP_W   = 2;
    localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_W  = PROD_W + ADDR_W;
    localparam int SHIFT  = COEF_BITS - 2;
    localparam int S_W    = ACC_W - SHIFT;

    localparam logic [CFG_W-1:0] PHASE_LEN_RST = CFG_W'(64);

    localparam logic signed [ACC_W-1:0] ROUND_ADD =
        ACC_W'({1'b1, {(SHIFT-1){1'b0}}});
    localparam logic signed [S_W-1:0] SAT_MAX =
        S_W'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
    localparam logic signed [S_W-1:0] SAT_MIN = ~SAT_MAX;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH  = 2'd0,
        OP_COEF  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef struct packed {
        logic clr;
        logic en;
    } t_mac_ctrl;

endpackage

>>> rtl/pi2x_in_if.sv
interface pi2x_in_if;
    logic                                  valid;
    logic                                  ready;
    logic [pi2x_pkg::OP_W-1:0]             operation;
    logic signed [pi2x_pkg::SAMPLE_BITS-1:0] sample;
    logic [pi2x_pkg::IDX_W-1:0]            coef_index;
    logic signed [pi2x_pkg::COEF_BITS-1:0] even_coef;
    logic signed [pi2x_pkg::COEF_BITS-1:0] odd_coef;

    modport source (
        output valid, operation, sample, coef_index, even_coef, odd_coef,
        input  ready
    );
    modport sink (
        input  valid, operation, sample, coef_index, even_coef, odd_coef,
        output ready
    );
endinterface

>>> rtl/pi2x_out_if.sv
interface pi2x_out_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [pi2x_pkg::SAMPLE_BITS-1:0] out_sample;
    logic                                    last;
    logic                                    saturated;

    modport source (
        output valid, out_sample, last, saturated,
        input  ready
    );
    modport sink (
        input  valid, out_sample, last, saturated,
        output ready
    );
endinterface

>>> rtl/pi2x_mac.sv
module pi2x_mac (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  pi2x_pkg::t_mac_ctrl                     i_ctrl,
    input  logic signed [pi2x_pkg::SAMPLE_BITS-1:0] i_x,
    input  logic signed [pi2x_pkg::COEF_BITS-1:0]   i_ce,
    input  logic signed [pi2x_pkg::COEF_BITS-1:0]   i_co,
    output logic signed [pi2x_pkg::ACC_W-1:0]       o_acc_e,
    output logic signed [pi2x_pkg::ACC_W-1:0]       o_acc_o,
    output logic                                    o_busy
);

    logic                                   r_pv;
    logic signed [pi2x_pkg::PROD_W-1:0]     r_prod_e;
    logic signed [pi2x_pkg::PROD_W-1:0]     r_prod_o;
    logic signed [pi2x_pkg::ACC_W-1:0]      r_acc_e;
    logic signed [pi2x_pkg::ACC_W-1:0]      r_acc_o;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else if (i_ctrl.clr) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_ctrl.en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en) begin
            r_prod_e <= i_x * i_ce;
            r_prod_o <= i_x * i_co;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.clr) begin
            r_acc_e <= '0;
            r_acc_o <= '0;
        end else if (r_pv) begin
            r_acc_e <= r_acc_e + {{pi2x_pkg::ADDR_W{r_prod_e[pi2x_pkg::PROD_W-1]}}, r_prod_e};
            r_acc_o <= r_acc_o + {{pi2x_pkg::ADDR_W{r_prod_o[pi2x_pkg::PROD_W-1]}}, r_prod_o};
        end
    end

    assign o_acc_e = r_acc_e;
    assign o_acc_o = r_acc_o;
    assign o_busy  = r_pv;

endmodule

>>> rtl/polyphase_interpolator_2x_core.sv
// Single-channel 2x polyphase FIR interpolator.
// i_in carries requests: push a sample, write one even/odd coefficient pair,
// or clear the history and write position. o_out returns two results per
// pushed sample, the even phase first and then the odd phase with last set.
// i_cfg_we and i_cfg_wdata set the phase length; write it only while idle.
// Coefficient writes, clears and ignored codes are taken while idle and the
// block stays ready. A push runs L tap pairs before the even result is
// shown, where L is the phase length with zero taken as one and anything
// above 64 taken as 64, through one dual multiply-accumulate unit that
// handles one tap pair per cycle through a three-stage memory read and
// multiply pipeline. The block accepts the next request only after the odd
// result has been taken. When the receiver stalls, the pending result is
// held and i_in stays not ready. Reset returns the phase length to 64, zeros
// the history, the write position and both tap stores, and leaves the block
// ready with no result.
module polyphase_interpolator_2x_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [pi2x_pkg::CFG_W-1:0]      i_cfg_wdata,
    pi2x_in_if.sink                         i_in,
    pi2x_out_if.source                      o_out
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_MAC   = 5'b00010,
        S_DRAIN = 5'b00100,
        S_OUT_E = 5'b01000,
        S_OUT_O = 5'b10000
    } t_state;

    t_state                                  r_state, n_state;
    logic [pi2x_pkg::CFG_W-1:0]              r_phase_length;
    logic [pi2x_pkg::ADDR_W-1:0]             r_wp;
    logic [pi2x_pkg::LEN_W-1:0]              r_len;
    logic [pi2x_pkg::LEN_W-1:0]              r_k;
    logic [pi2x_pkg::ADDR_W-1:0]             r_h;
    logic                                    r_rd_v;

    logic signed [pi2x_pkg::SAMPLE_BITS-1:0] r_hist_mem [pi2x_pkg::MAX_TAPS];
    logic signed [pi2x_pkg::COEF_BITS-1:0]   r_even_mem [pi2x_pkg::MAX_TAPS];
    logic signed [pi2x_pkg::COEF_BITS-1:0]   r_odd_mem  [pi2x_pkg::MAX_TAPS];
    logic [pi2x_pkg::MAX_TAPS-1:0]           r_hist_vld;
    logic [pi2x_pkg::MAX_TAPS-1:0]           r_tap_vld;

    logic signed [pi2x_pkg::SAMPLE_BITS-1:0] r_hist_rd;
    logic signed [pi2x_pkg::COEF_BITS-1:0]   r_even_rd;
    logic signed [pi2x_pkg::COEF_BITS-1:0]   r_odd_rd;
    logic                                    r_hist_rd_vld;
    logic                                    r_tap_rd_vld;

    logic signed [pi2x_pkg::SAMPLE_BITS-1:0] r_out_e, r_out_o;
    logic                                    r_sat_e, r_sat_o;

    pi2x_pkg::t_op                           in_op;
    logic                                    in_fire, out_fire, push_fire, coef_fire, clr_fire;
    logic [pi2x_pkg::LEN_W-1:0]              len_eff;
    logic [pi2x_pkg::LEN_W-1:0]              pos_inc;
    logic [pi2x_pkg::ADDR_W-1:0]             pos;
    logic [pi2x_pkg::ADDR_W-1:0]             coef_addr;
    logic                                    coef_ok;
    logic                                    k_last;
    logic                                    issue;
    pi2x_pkg::t_mac_ctrl                     mac_ctrl;
    logic signed [pi2x_pkg::SAMPLE_BITS-1:0] mac_x;
    logic signed [pi2x_pkg::COEF_BITS-1:0]   mac_ce, mac_co;
    logic signed [pi2x_pkg::ACC_W-1:0]       acc_e, acc_o;
    logic                                    mac_busy;
    logic [pi2x_pkg::SAMPLE_BITS:0]          fin_e, fin_o;

    function automatic logic [pi2x_pkg::SAMPLE_BITS:0] f_finish(
        input logic signed [pi2x_pkg::ACC_W-1:0] acc
    );
        logic signed [pi2x_pkg::ACC_W-1:0] rnd;
        logic signed [pi2x_pkg::S_W-1:0]   s;
        rnd = acc + pi2x_pkg::ROUND_ADD;
        s   = rnd[pi2x_pkg::ACC_W-1:pi2x_pkg::SHIFT];
        if (s > pi2x_pkg::SAT_MAX) begin
            f_finish = {1'b1, pi2x_pkg::SAT_MAX[pi2x_pkg::SAMPLE_BITS-1:0]};
        end else if (s < pi2x_pkg::SAT_MIN) begin
            f_finish = {1'b1, pi2x_pkg::SAT_MIN[pi2x_pkg::SAMPLE_BITS-1:0]};
        end else begin
            f_finish = {1'b0, s[pi2x_pkg::SAMPLE_BITS-1:0]};
        end
    endfunction

    assign in_op     = pi2x_pkg::t_op'(i_in.operation);
    assign in_fire   = i_in.valid && i_in.ready;
    assign out_fire  = o_out.valid && o_out.ready;
    assign push_fire = in_fire && (in_op == pi2x_pkg::OP_PUSH);
    assign coef_fire = in_fire && (in_op == pi2x_pkg::OP_COEF);
    assign clr_fire  = in_fire && (in_op == pi2x_pkg::OP_CLEAR);

    always_comb begin
        if (r_phase_length == '0) begin
            len_eff = pi2x_pkg::LEN_W'(1);
        end else if (int'(r_phase_length) > pi2x_pkg::MAX_TAPS) begin
            len_eff = pi2x_pkg::LEN_W'(pi2x_pkg::MAX_TAPS);
        end else begin
            len_eff = pi2x_pkg::LEN_W'(r_phase_length);
        end
    end

    assign pos_inc   = pi2x_pkg::LEN_W'(r_wp) + pi2x_pkg::LEN_W'(1);
    assign pos       = (pos_inc >= len_eff) ? '0 : pos_inc[pi2x_pkg::ADDR_W-1:0];
    assign coef_addr = pi2x_pkg::ADDR_W'(i_in.coef_index);
    assign coef_ok   = int'(i_in.coef_index) < pi2x_pkg::MAX_TAPS;
    assign issue     = (r_state == S_MAC);
    assign k_last    = (r_k == r_len - pi2x_pkg::LEN_W'(1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (push_fire) begin
                    n_state = S_MAC;
                end
            end
            S_MAC: begin
                if (k_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!r_rd_v && !mac_busy) begin
                    n_state = S_OUT_E;
                end
            end
            S_OUT_E: begin
                if (out_fire) begin
                    n_state = S_OUT_O;
                end
            end
            S_OUT_O: begin
                if (out_fire) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_phase_length <= pi2x_pkg::PHASE_LEN_RST;
            r_wp           <= '0;
            r_rd_v         <= 1'b0;
            r_hist_vld     <= '0;
            r_tap_vld      <= '0;
        end else begin
            r_state <= n_state;
            r_rd_v  <= issue;
            if (i_cfg_we) begin
                r_phase_length <= i_cfg_wdata;
            end
            if (push_fire) begin
                r_wp             <= pos;
                r_hist_vld[pos]  <= 1'b1;
            end
            if (clr_fire) begin
                r_wp       <= '0;
                r_hist_vld <= '0;
            end
            if (coef_fire && coef_ok) begin
                r_tap_vld[coef_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_fire) begin
            r_len <= len_eff;
            r_k   <= '0;
            r_h   <= pos;
        end else if (issue) begin
            r_k <= r_k + pi2x_pkg::LEN_W'(1);
            r_h <= (r_h == '0) ? pi2x_pkg::ADDR_W'(r_len - pi2x_pkg::LEN_W'(1))
                               : r_h - pi2x_pkg::ADDR_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_fire) begin
            r_hist_mem[pos] <= i_in.sample;
        end
        r_hist_rd     <= r_hist_mem[r_h];
        r_hist_rd_vld <= r_hist_vld[r_h];
    end

    always_ff @(posedge i_clk) begin
        if (coef_fire && coef_ok) begin
            r_even_mem[coef_addr] <= i_in.even_coef;
            r_odd_mem[coef_addr]  <= i_in.odd_coef;
        end
        r_even_rd    <= r_even_mem[r_k[pi2x_pkg::ADDR_W-1:0]];
        r_odd_rd     <= r_odd_mem[r_k[pi2x_pkg::ADDR_W-1:0]];
        r_tap_rd_vld <= r_tap_vld[r_k[pi2x_pkg::ADDR_W-1:0]];
    end

    assign mac_x        = r_hist_rd_vld ? r_hist_rd : '0;
    assign mac_ce       = r_tap_rd_vld ? r_even_rd : '0;
    assign mac_co       = r_tap_rd_vld ? r_odd_rd : '0;
    assign mac_ctrl.clr = push_fire;
    assign mac_ctrl.en  = r_rd_v;

    pi2x_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (mac_ctrl),
        .i_x     (mac_x),
        .i_ce    (mac_ce),
        .i_co    (mac_co),
        .o_acc_e (acc_e),
        .o_acc_o (acc_o),
        .o_busy  (mac_busy)
    );

    assign fin_e = f_finish(acc_e);
    assign fin_o = f_finish(acc_o);

    always_ff @(posedge i_clk) begin
        if (r_state == S_DRAIN) begin
            r_out_e <= fin_e[pi2x_pkg::SAMPLE_BITS-1:0];
            r_sat_e <= fin_e[pi2x_pkg::SAMPLE_BITS];
            r_out_o <= fin_o[pi2x_pkg::SAMPLE_BITS-1:0];
            r_sat_o <= fin_o[pi2x_pkg::SAMPLE_BITS];
        end
    end

    assign i_in.ready       = (r_state == S_IDLE);
    assign o_out.valid      = (r_state == S_OUT_E) || (r_state == S_OUT_O);
    assign o_out.out_sample = (r_state == S_OUT_O) ? r_out_o : r_out_e;
    assign o_out.last       = (r_state == S_OUT_O);
    assign o_out.saturated  = (r_state == S_OUT_O) ? r_sat_o : r_sat_e;

endmodule

>>> rtl/pi2x_chk.sv
`include "polyphase_interpolator_2x_core_defines.svh"

module pi2x_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic [pi2x_pkg::OP_W-1:0]   i_in_op,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic                        i_out_last
);

    logic push_fire;
    logic even_fire;
    logic odd_fire;
    logic idle_seen;
    logic odd_shown;
    logic ready_and_valid;

    assign push_fire       = i_in_valid && i_in_ready && (i_in_op == pi2x_pkg::OP_PUSH);
    assign even_fire       = i_out_valid && i_out_ready && !i_out_last;
    assign odd_fire        = i_out_valid && i_out_ready && i_out_last;
    assign idle_seen       = i_in_ready && !i_out_valid;
    assign odd_shown       = i_out_valid && i_out_last;
    assign ready_and_valid = i_in_ready && i_out_valid;

    `PI2X_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> idle_seen, "not idle after reset")
    `PI2X_ASSERT(a_no_overlap, i_clk, i_rst_n, !ready_and_valid, "ready while a result waits")
    `PI2X_ASSERT(a_push_busy, i_clk, i_rst_n, push_fire |=> !i_in_ready, "ready after a push")
    `PI2X_ASSERT(a_odd_follows, i_clk, i_rst_n, even_fire |=> odd_shown, "odd result not next")
    `PI2X_ASSERT(a_idle_after_pair, i_clk, i_rst_n, odd_fire |=> idle_seen, "busy after the pair")

endmodule

bind polyphase_interpolator_2x_core pi2x_chk u_pi2x_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_op     (i_in.operation),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_last  (o_out.last)
);

>>> tb/polyphase_interpolator_2x_core_test.sv
module polyphase_interpolator_2x_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pi2x_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int SETTLE_WAIT  = 80;
    localparam int END_WAIT     = 100;
    localparam int HOLD_CYCLES  = 500;
    localparam int N_PHASES     = 6;

    typedef struct packed {
        t_op                           op;
        logic signed [SAMPLE_BITS-1:0] sample;
        logic [IDX_W-1:0]              coef_index;
        logic signed [COEF_BITS-1:0]   even_coef;
        logic signed [COEF_BITS-1:0]   odd_coef;
    } t_request;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] out_sample;
        logic                          last;
        logic                          saturated;
    } t_result;

    typedef struct {
        bit               is_cfg;
        logic [CFG_W-1:0] cfg_value;
        t_request         req;
        bit               typed;
        t_result          even_res;
        t_result          odd_res;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_W-1:0] i_cfg_wdata;

    pi2x_in_if  in_if();
    pi2x_out_if out_if();

    polyphase_interpolator_2x_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Filter state mirrored by the testbench.
    logic signed [SAMPLE_BITS-1:0] sample_history [MAX_TAPS];
    logic signed [COEF_BITS-1:0]   tap_even [MAX_TAPS];
    logic signed [COEF_BITS-1:0]   tap_odd [MAX_TAPS];
    int                            write_pos;
    logic [CFG_W-1:0]              cur_phase_length;

    t_result awaited_samples [$];
    int      mismatch_count = 0;
    int      cycle_count = 0;
    int      sender_idle_pct = 0;
    int      receiver_stall_pct = 0;
    bit      hold_req = 1'b0;
    int      hold_left = 0;
    t_result seen_sample;
    t_result wanted_sample;

    function automatic t_result round_and_clamp(input longint acc, input logic is_odd);
        t_result res;
        longint  s;
        longint  max_v;
        max_v = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
        s = (acc + (longint'(1) <<< (SHIFT - 1))) >>> SHIFT;
        res.last = is_odd;
        res.saturated = 1'b0;
        if (s > max_v) begin
            s = max_v;
            res.saturated = 1'b1;
        end else if (s < -max_v - 1) begin
            s = -max_v - 1;
            res.saturated = 1'b1;
        end
        res.out_sample = s[SAMPLE_BITS-1:0];
        return res;
    endfunction

    function automatic int interpolate_step(input t_request r, output t_result ev,
                                            output t_result od);
        int     len;
        int     h;
        longint acc_e;
        longint acc_o;
        ev = '0;
        od = '0;
        if (r.op == OP_COEF) begin
            tap_even[r.coef_index] = r.even_coef;
            tap_odd[r.coef_index] = r.odd_coef;
            return 0;
        end
        if (r.op == OP_CLEAR) begin
            foreach (sample_history[i]) sample_history[i] = '0;
            write_pos = 0;
            return 0;
        end
        if (r.op != OP_PUSH) begin
            return 0;
        end
        len = int'(cur_phase_length);
        if (len == 0) len = 1;
        if (len > MAX_TAPS) len = MAX_TAPS;
        write_pos = write_pos + 1;
        if (write_pos >= len) write_pos = 0;
        sample_history[write_pos] = r.sample;
        acc_e = 0;
        acc_o = 0;
        h = write_pos;
        for (int k = 0; k < len; k++) begin
            acc_e += longint'(tap_even[k]) * longint'(sample_history[h]);
            acc_o += longint'(tap_odd[k]) * longint'(sample_history[h]);
            h = (h == 0) ? len - 1 : h - 1;
        end
        ev = round_and_clamp(acc_e, 1'b0);
        od = round_and_clamp(acc_o, 1'b1);
        return 2;
    endfunction

    function automatic t_row row_blank();
        t_row r;
        r.is_cfg = 1'b0;
        r.cfg_value = '0;
        r.req = '0;
        r.typed = 1'b0;
        r.even_res = '0;
        r.odd_res = '0;
        return r;
    endfunction

    function automatic t_row row_push(input logic signed [SAMPLE_BITS-1:0] s);
        t_row r;
        r = row_blank();
        r.req.op = OP_PUSH;
        r.req.sample = s;
        return r;
    endfunction

    function automatic t_row row_checked(input logic signed [SAMPLE_BITS-1:0] s,
                                         input logic signed [SAMPLE_BITS-1:0] ev,
                                         input logic ev_sat,
                                         input logic signed [SAMPLE_BITS-1:0] od,
                                         input logic od_sat);
        t_row r;
        r = row_push(s);
        r.typed = 1'b1;
        r.even_res = '{out_sample: ev, last: 1'b0, saturated: ev_sat};
        r.odd_res = '{out_sample: od, last: 1'b1, saturated: od_sat};
        return r;
    endfunction

    function automatic t_row row_coef(input logic [IDX_W-1:0] idx,
                                      input logic signed [COEF_BITS-1:0] ev,
                                      input logic signed [COEF_BITS-1:0] od);
        t_row r;
        r = row_blank();
        r.req.op = OP_COEF;
        r.req.coef_index = idx;
        r.req.even_coef = ev;
        r.req.odd_coef = od;
        return r;
    endfunction

    function automatic t_row row_op(input t_op op);
        t_row r;
        r = row_blank();
        r.req.op = op;
        return r;
    endfunction

    function automatic t_row row_cfg(input logic [CFG_W-1:0] v);
        t_row r;
        r = row_blank();
        r.is_cfg = 1'b1;
        r.cfg_value = v;
        return r;
    endfunction

    function automatic logic signed [COEF_BITS-1:0] random_coef();
        logic signed [COEF_BITS-1:0] c;
        c = COEF_BITS'($urandom());
        case ($urandom_range(0, 5))
            0: c = $urandom_range(0, 1) ? {1'b0, {(COEF_BITS-1){1'b1}}}
                                        : {1'b1, {(COEF_BITS-1){1'b0}}};
            1: ;
            default: c = {{(COEF_BITS-18){c[17]}}, c[17:0]};
        endcase
        return c;
    endfunction

    function automatic t_request random_request();
        t_request r;
        int       pick;
        pick = $urandom_range(0, 99);
        if (pick < 70) r.op = OP_PUSH;
        else if (pick < 88) r.op = OP_COEF;
        else if (pick < 95) r.op = OP_CLEAR;
        else r.op = OP_NONE;
        case ($urandom_range(0, 7))
            0: r.sample = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
            1: r.sample = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
            2: r.sample = $urandom_range(0, 1) ? '1 : '0;
            default: r.sample = SAMPLE_BITS'($urandom());
        endcase
        r.coef_index = IDX_W'($urandom_range(0, MAX_TAPS - 1));
        r.even_coef = random_coef();
        r.odd_coef = random_coef();
        return r;
    endfunction

    task automatic send_request(input t_request r);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.operation  <= r.op;
        in_if.sample     <= r.sample;
        in_if.coef_index <= r.coef_index;
        in_if.even_coef  <= r.even_coef;
        in_if.odd_coef   <= r.odd_coef;
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    task automatic wait_for_outputs();
        in_if.valid <= 1'b0;
        while (awaited_samples.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_phase_length(input logic [CFG_W-1:0] v);
        wait_for_outputs();
        // A trailing coefficient write or clear may still be in flight.
        repeat (SETTLE_WAIT) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_phase_length = v;
    endtask

    task automatic issue_and_predict(input t_request r, input bit typed,
                                     input t_result typed_ev, input t_result typed_od);
        t_result ev;
        t_result od;
        send_request(r);
        if (interpolate_step(r, ev, od) == 2) begin
            awaited_samples.push_back(typed ? typed_ev : ev);
            awaited_samples.push_back(typed ? typed_od : od);
        end
    endtask

    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            seen_sample = '{out_sample: out_if.out_sample, last: out_if.last,
                            saturated: out_if.saturated};
            if (awaited_samples.size() == 0) begin
                $display("%0t: unexpected output, got %0d last %0b sat %0b", $time,
                         $signed(seen_sample.out_sample), seen_sample.last,
                         seen_sample.saturated);
                mismatch_count++;
            end else begin
                wanted_sample = awaited_samples.pop_front();
                if (seen_sample !== wanted_sample) begin
                    $display("%0t: output mismatch, expected %0d last %0b sat %0b, got %0d last %0b sat %0b",
                             $time, $signed(wanted_sample.out_sample), wanted_sample.last,
                             wanted_sample.saturated, $signed(seen_sample.out_sample),
                             seen_sample.last, seen_sample.saturated);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        t_row     rows [24];
        int       phase_cfg [N_PHASES];
        int       phase_sidle [N_PHASES];
        int       phase_rstall [N_PHASES];
        int       phase_items [N_PHASES];
        t_request rq;

        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_wdata      <= '0;
        in_if.valid      <= 1'b0;
        in_if.operation  <= OP_NONE;
        in_if.sample     <= '0;
        in_if.coef_index <= '0;
        in_if.even_coef  <= '0;
        in_if.odd_coef   <= '0;

        foreach (sample_history[i]) sample_history[i] = '0;
        foreach (tap_even[i]) tap_even[i] = '0;
        foreach (tap_odd[i]) tap_odd[i] = '0;
        write_pos = 0;
        cur_phase_length = PHASE_LEN_RST;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        rows = '{
            row_checked(24'sh7FFFFF, 24'sd0, 1'b0, 24'sd0, 1'b0),
            row_checked(24'sh800000, 24'sd0, 1'b0, 24'sd0, 1'b0),
            row_op(OP_NONE),
            row_coef(6'd0, 24'sh400000, 24'shC00000),
            row_op(OP_CLEAR),
            row_checked(24'sh7FFFFF, 24'sh7FFFFF, 1'b0, 24'sh800001, 1'b0),
            row_checked(24'sh800000, 24'sh800000, 1'b0, 24'sh7FFFFF, 1'b1),
            row_coef(6'd63, 24'sh7FFFFF, 24'sh800000),
            row_coef(6'd1, 24'sh7FFFFF, 24'sh800000),
            row_push(24'sh7FFFFF),
            row_push(24'sd0),
            row_push(-24'sd1),
            row_cfg(7'd3),
            row_push(24'sd12345),
            row_push(24'sh800000),
            row_cfg(7'd0),
            row_push(24'sh7FFFFF),
            row_push(24'sd1),
            row_cfg(7'd127),
            row_push(-24'sd1),
            row_cfg(7'd1),
            row_push(24'sd4660),
            row_cfg(7'd64),
            row_push(-24'sd4660)
        };

        foreach (rows[i]) begin
            if (rows[i].is_cfg) begin
                set_phase_length(rows[i].cfg_value);
            end else begin
                issue_and_predict(rows[i].req, rows[i].typed, rows[i].even_res,
                                  rows[i].odd_res);
            end
        end

        phase_cfg    = '{64, 1, $urandom_range(2, 63), 0, 127, $urandom_range(1, 64)};
        phase_sidle  = '{0, 66, 0, 33, 0, 33};
        phase_rstall = '{0, 0, 66, 33, 0, 33};
        phase_items  = '{200, 150, 250, 150, 150, 200};

        for (int p = 0; p < N_PHASES; p++) begin
            set_phase_length(CFG_W'(phase_cfg[p]));
            sender_idle_pct    = phase_sidle[p];
            receiver_stall_pct = phase_rstall[p];
            // The receiver holds off while requests keep coming, so the block backs up.
            if (p == 4) hold_req = 1'b1;
            for (int n = 0; n < phase_items[p]; n++) begin
                rq = random_request();
                issue_and_predict(rq, 1'b0, '0, '0);
            end
        end

        wait_for_outputs();
        repeat (END_WAIT) @(posedge i_clk);
        if (mismatch_count == 0 && awaited_samples.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

>>> polyphase_interpolator_2x_core.f
+incdir+rtl
rtl/pi2x_pkg.sv
rtl/pi2x_in_if.sv
rtl/pi2x_out_if.sv
rtl/pi2x_mac.sv
rtl/polyphase_interpolator_2x_core.sv
rtl/pi2x_chk.sv
tb/polyphase_interpolator_2x_core_test.sv
